// ===== design/ltc_pkg.sv =====
// Shared types, keyword and operator tables for the lexeme token classifier.
package ltc_pkg;

    localparam int NumKeywords  = 62;
    localparam int NumOperators = 34;
    localparam int MaxKeywordLen = 16;
    localparam int KwCharMax = 16;
    localparam logic [4:0] PosMax = 5'd31;

    typedef logic [7:0] char_t;
    typedef logic [NumKeywords-1:0] kw_mask_t;

    typedef enum logic [2:0] {
        CLS_KEYWORD    = 3'd0,
        CLS_IDENTIFIER = 3'd1,
        CLS_OPERATOR   = 3'd2,
        CLS_FLOAT      = 3'd3,
        CLS_INTEGER    = 3'd4,
        CLS_OTHER      = 3'd5
    } token_class_t;

    // Word handed from the front part to the back part at lexeme end.
    typedef struct packed {
        logic       is_kw;
        logic       ident_ok;
        logic       op_len_ok;
        logic [1:0] op_len;
        logic [23:0] op_chars;
        logic       numeric_ok;
        logic [1:0] dots;
        logic       digits_ok;
    } lex_flags_t;

    typedef struct packed {
        logic [4:0]             len;
        logic [KwCharMax*8-1:0] text;
    } kw_entry_t;

    function automatic kw_entry_t kw_rom(input int idx);
        kw_entry_t e;
        string s;
        e = '0;
        case (idx)
            0: s = "Auto";        1: s = "double";      2: s = "int";
            3: s = "struct";      4: s = "Break";       5: s = "else";
            6: s = "long";        7: s = "switch";      8: s = "Case";
            9: s = "enum";        10: s = "register";   11: s = "typedef";
            12: s = "Char";       13: s = "extern";     14: s = "return";
            15: s = "union";      16: s = "Const";      17: s = "float";
            18: s = "short";      19: s = "unsigned";   20: s = "Continue";
            21: s = "for";        22: s = "signed";     23: s = "void";
            24: s = "Default";    25: s = "goto";       26: s = "sizeof";
            27: s = "volatile";   28: s = "Do";         29: s = "if";
            30: s = "static";     31: s = "while";      32: s = "Asm";
            33: s = {"dynamic", "_cast"}; 34: s = "namespace";
            35: s = {"reinterpret", "_cast"}; 36: s = "Bool";  37: s = "explicit";
            38: s = "new";        39: s = {"static", "_cast"}; 40: s = "Catch";
            41: s = "false";      42: s = "operator";   43: s = "template";
            44: s = "Class";      45: s = "friend";     46: s = "private";
            47: s = "this";       48: s = {"Const", "_cast"}; 49: s = "inline";
            50: s = "public";     51: s = "throw";      52: s = "Delete";
            53: s = "mutable";    54: s = "protected";  55: s = "true";
            56: s = "Try";        57: s = "typeid";     58: s = "typename";
            59: s = "using";      60: s = "virtual";    61: s = "wchar_t";
            default: s = "";
        endcase
        e.len = 5'(s.len());
        for (int i = 0; i < KwCharMax; i++) begin
            if (i < s.len()) begin
                e.text[i*8 +: 8] = s[i];
            end
        end
        return e;
    endfunction

    // Operator text, first character in the low byte, plus its length.
    function automatic logic [25:0] op_rom(input int idx);
        string s;
        logic [25:0] r;
        r = '0;
        case (idx)
            0: s = "+";   1: s = "-";   2: s = "*";   3: s = "/";   4: s = "=";
            5: s = "%";   6: s = "<";   7: s = ">";   8: s = "<=";  9: s = ">=";
            10: s = "=="; 11: s = "!="; 12: s = "++"; 13: s = "--"; 14: s = "&&";
            15: s = "||"; 16: s = "&";  17: s = "|";  18: s = "^";  19: s = "~";
            20: s = "<<"; 21: s = ">>"; 22: s = "+="; 23: s = "-="; 24: s = "*=";
            25: s = "/="; 26: s = "%="; 27: s = "<<="; 28: s = ">>="; 29: s = "&=";
            30: s = "^="; 31: s = "|="; 32: s = ";";  33: s = ",";
            default: s = "";
        endcase
        r[25:24] = 2'(s.len());
        for (int i = 0; i < 3; i++) begin
            if (i < s.len()) begin
                r[i*8 +: 8] = s[i];
            end
        end
        return r;
    endfunction

endpackage

// ===== design/ltc_front.sv =====
// Front part: per-character scan that builds keyword, identifier, operator and numeric flags.
module ltc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ltc_pkg::char_t      char_code,
    input  logic                last_char,
    input  logic                accept,
    output logic                flags_valid,
    output ltc_pkg::lex_flags_t flags
);
    import ltc_pkg::*;

    kw_mask_t    kw_hits_reg, kw_hits_next;
    logic [4:0]  pos_reg;
    logic        ident_reg, digits_reg, numeric_reg;
    logic [1:0]  dots_reg;
    logic [23:0] opc_reg;

    logic        letter, digit, under, dot;
    logic        ident_n, digits_n, numeric_n;
    logic [1:0]  dots_n;
    logic [23:0] opc_n;
    logic        any_kw;
    kw_entry_t   ke;

    assign letter = (char_code >= "a" && char_code <= "z")
                 || (char_code >= "A" && char_code <= "Z");
    assign digit  = char_code >= "0" && char_code <= "9";
    assign under  = char_code == "_";
    assign dot    = char_code == ".";

    always_comb
    begin
        ident_n   = ident_reg && (letter || under || (pos_reg != 5'd0 && digit));
        digits_n  = digits_reg && digit;
        numeric_n = numeric_reg && (digit || dot);
        dots_n    = (dot && dots_reg != 2'd2) ? dots_reg + 2'd1 : dots_reg;
        opc_n     = opc_reg;
        if (pos_reg < 5'd3) begin
            opc_n[pos_reg[1:0]*8 +: 8] = char_code;
        end
        kw_hits_next = '0;
        any_kw = 1'b0;
        for (int k = 0; k < NumKeywords; k++) begin
            ke = kw_rom(k);
            if (pos_reg < 5'(MaxKeywordLen)) begin
                kw_hits_next[k] = kw_hits_reg[k] && pos_reg < ke.len
                    && ke.text[pos_reg[3:0]*8 +: 8] == char_code;
            end
            if (kw_hits_next[k] && pos_reg != PosMax && ke.len == pos_reg + 5'd1) begin
                any_kw = 1'b1;
            end
        end
    end

    always_comb
    begin
        flags_valid      = in_valid && last_char;
        flags.is_kw      = any_kw;
        flags.ident_ok   = ident_n;
        flags.op_len_ok  = pos_reg < 5'd3;
        flags.op_len     = 2'(pos_reg + 5'd1);
        flags.op_chars   = opc_n;
        flags.numeric_ok = numeric_n;
        flags.dots       = dots_n;
        flags.digits_ok  = digits_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kw_hits_reg <= '1;
            pos_reg     <= '0;
            ident_reg   <= 1'b1;
            digits_reg  <= 1'b1;
            numeric_reg <= 1'b1;
            dots_reg    <= '0;
            opc_reg     <= '0;
        end else if (accept) begin
            if (last_char) begin
                kw_hits_reg <= '1;
                pos_reg     <= '0;
                ident_reg   <= 1'b1;
                digits_reg  <= 1'b1;
                numeric_reg <= 1'b1;
                dots_reg    <= '0;
                opc_reg     <= '0;
            end else begin
                kw_hits_reg <= kw_hits_next;
                pos_reg     <= (pos_reg == PosMax) ? pos_reg : pos_reg + 5'd1;
                ident_reg   <= ident_n;
                digits_reg  <= digits_n;
                numeric_reg <= numeric_n;
                dots_reg    <= dots_n;
                opc_reg     <= opc_n;
            end
        end
    end

endmodule

// ===== design/ltc_queue.sv =====
// Two-entry queue of lexeme flag words between front and back parts.
module ltc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ltc_pkg::lex_flags_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output logic                empty,
    output ltc_pkg::lex_flags_t rd_data
);
    import ltc_pkg::*;

    lex_flags_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) begin
                wp_reg <= ~wp_reg;
            end
            if (rd_en) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en || rd_en) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !rd_en) else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");

endmodule

// ===== design/ltc_back.sv =====
// Back part: priority classification, operator lookup and output register.
module ltc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  ltc_pkg::lex_flags_t q_data,
    output logic                q_rd,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          token_class,
    output logic [5:0]          operator_kind
);
    import ltc_pkg::*;

    logic         valid_reg;
    token_class_t cls_reg, cls_next;
    logic [5:0]   opk_reg, opk_next, opk_hit;
    logic [25:0]  oe;

    assign q_rd = !q_empty && (!valid_reg || !out_stall);

    always_comb
    begin
        opk_hit = '0;
        for (int k = NumOperators - 1; k >= 0; k--) begin
            oe = op_rom(k);
            if (q_data.op_len_ok && oe[25:24] == q_data.op_len
                && (oe[7:0] == q_data.op_chars[7:0])
                && (q_data.op_len < 2'd2 || oe[15:8] == q_data.op_chars[15:8])
                && (q_data.op_len < 2'd3 || oe[23:16] == q_data.op_chars[23:16])) begin
                opk_hit = 6'(k + 1);
            end
        end
        opk_next = '0;
        if (q_data.is_kw) begin
            cls_next = CLS_KEYWORD;
        end else if (q_data.ident_ok) begin
            cls_next = CLS_IDENTIFIER;
        end else if (opk_hit != 6'd0) begin
            cls_next = CLS_OPERATOR;
            opk_next = opk_hit;
        end else if (q_data.numeric_ok && q_data.dots == 2'd1) begin
            cls_next = CLS_FLOAT;
        end else if (q_data.digits_ok) begin
            cls_next = CLS_INTEGER;
        end else begin
            cls_next = CLS_OTHER;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd) begin
            cls_reg <= cls_next;
            opk_reg <= opk_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (q_rd) begin
            valid_reg <= 1'b1;
        end else if (!out_stall) begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid     = valid_reg;
    assign token_class   = cls_reg;
    assign operator_kind = opk_reg;

    a_opk_only_op: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && cls_reg != CLS_OPERATOR |-> opk_reg == 6'd0)
        else $error("operator kind set on non-operator");
    a_op_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && cls_reg == CLS_OPERATOR |-> opk_reg != 6'd0)
        else $error("operator without kind");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_stall |=> valid_reg && $stable(cls_reg))
        else $error("result lost under stall");

endmodule

// ===== design/lexeme_token_classifier.sv =====
// Top level: lexeme token classifier.
//   channel | direction | handshake          | fields
//   in      | input     | in_valid/in_stall  | char_code, last_char
//   out     | output    | out_valid/out_stall| token_class, operator_kind
// One character is accepted every cycle while in_stall is low; the result is offered once
// the flag word of the last character has passed the queue write, then the classify register.
// A two-entry queue of flag words lets the input run while the output stalls;
// input stalls only when that queue is full and the back part cannot drain.
// Reset (rst_n low) clears the scan state, the queue and the output valid.
module lexeme_token_classifier (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ltc_pkg::char_t char_code,
    input  logic           last_char,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     token_class,
    output logic [5:0]     operator_kind
);
    import ltc_pkg::*;

    logic       accept, fv, q_full, q_empty, q_rd;
    lex_flags_t fl, qd;

    assign in_stall = q_full && !q_rd;
    assign accept   = in_valid && !in_stall;

    ltc_front u_front (
        .clk, .rst_n, .in_valid, .char_code, .last_char, .accept,
        .flags_valid(fv), .flags(fl)
    );

    ltc_queue u_queue (
        .clk, .rst_n, .wr_en(accept && fv), .wr_data(fl), .full(q_full),
        .rd_en(q_rd), .empty(q_empty), .rd_data(qd)
    );

    ltc_back u_back (
        .clk, .rst_n, .q_empty, .q_data(qd), .q_rd, .out_valid, .out_stall,
        .token_class, .operator_kind
    );

endmodule
